// File: rtl/otc_pkg.sv
// Shared types and constants for the oven timer controller.
// Holds the state encodings, the register set, and the item and result records.
// No dependencies.
package otc_pkg;

  localparam int LED_COUNT = 8;

  localparam logic [7:0] ALL_LEDS = 8'((1 << LED_COUNT) - 1);
  localparam logic [9:0] TEMP_RESET = 10'd350;
  localparam logic [9:0] TEMP_MAX = 10'd1023;
  localparam logic [8:0] PERIOD_MAX = 9'd510;

  localparam logic [3:0] TPS_RESET = 4'd5;
  localparam logic [7:0] HOLD_RESET = 8'd5;
  localparam logic [9:0] BAKE_BASE_RESET = 10'd300;
  localparam logic [9:0] BROIL_RESET = 10'd500;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAKE_TEMP_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BROIL_TEMPERATURE = 2'd3;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    ST_SETUP  = 3'd0,
    ST_SELECT = 3'd1,
    ST_COOK   = 3'd2,
    ST_RESETP = 3'd3,
    ST_DONE   = 3'd4
  } otc_oven_state_t;

  typedef enum logic [1:0] {
    MODE_BAKE  = 2'd0,
    MODE_TOAST = 2'd1,
    MODE_BROIL = 2'd2
  } otc_mode_t;

  typedef struct packed {
    logic [3:0] ticks_per_second;
    logic [7:0] hold_ticks;
    logic [9:0] bake_temp_base;
    logic [9:0] broil_temperature;
  } otc_cfg_t;

  typedef struct packed {
    logic       tick;
    logic       adc_valid;
    logic [9:0] adc_sample;
    logic       button3_down;
    logic       button3_up;
    logic       button4_down;
    logic       button4_up;
  } otc_item_t;

  typedef struct packed {
    otc_oven_state_t oven_state;
    otc_mode_t       mode_reg;
    logic            edit_flag;
    logic [9:0]      temp_setting;
    logic [9:0]      saved_temp;
    logic [8:0]      set_time;
    logic [8:0]      remaining_time;
    logic [15:0]     free_time;
    logic [15:0]     press_stamp;
    logic [3:0]      second_phase;
    logic [8:0]      led_period;
    logic [3:0]      led_spread;
    logic [8:0]      led_ticks;
    logic [7:0]      led_reg;
    logic            invert_flag;
  } otc_regs_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic [1:0] cook_mode;
    logic [8:0] shown_time;
    logic [9:0] temperature;
    logic [7:0] led_bar;
    logic       display_inverted;
    logic       editing_temperature;
  } otc_result_t;

endpackage

// File: rtl/otc_in_reg.sv
// Input register of the oven timer controller: takes one event transaction
// and unpacks it into an item record. Depends on otc_pkg.
module otc_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tick, adc_sample[9:0], button3_down, button3_up, button4_down, button4_up
  input  logic [otc_pkg::IN_DATA_W-1:0] s_tdata,
  // adc_valid
  input  logic                          s_tuser,
  input  logic                          advance,
  output logic                          item_valid,
  output otc_pkg::otc_item_t            item
);
  import otc_pkg::*;

  logic accept;

  assign s_tready = !item_valid || advance;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.tick         <= s_tdata[0];
      item.adc_valid    <= s_tuser;
      item.adc_sample   <= s_tdata[10:1];
      item.button3_down <= s_tdata[11];
      item.button3_up   <= s_tdata[12];
      item.button4_down <= s_tdata[13];
      item.button4_up   <= s_tdata[14];
    end
  end

endmodule

// File: rtl/otc_update.sv
// Next-state and result logic of the oven timer controller for one event item.
// Purely combinational; depends on otc_pkg.
module otc_update (
  input  otc_pkg::otc_cfg_t    cfg,
  input  otc_pkg::otc_item_t   item,
  input  otc_pkg::otc_regs_t   st,
  output otc_pkg::otc_regs_t   st_next,
  output otc_pkg::otc_result_t result
);
  import otc_pkg::*;

  logic [15:0] held;
  logic        long_hold;
  logic [7:0]  knob;
  logic [10:0] temp_sum;
  logic [12:0] total;
  logic [12:0] quot;
  logic [8:0]  lt_inc;
  logic        led_shift;
  logic [8:0]  ck_led_ticks;
  logic [3:0]  ck_spread;
  logic [7:0]  ck_led;
  logic [8:0]  ck_rem;
  logic        ck_done;
  logic [3:0]  ck_phase;
  otc_mode_t   new_mode;

  always_comb begin
    knob = item.adc_sample[9:2];
    temp_sum = 11'(knob) + {1'b0, cfg.bake_temp_base};

    lt_inc = st.led_ticks + 9'd1;
    led_shift = ((st.led_spread != 4'd0) && ({1'b0, lt_inc} == {1'b0, st.led_period} + 10'd1))
      || ((st.led_spread == 4'd0) && (lt_inc == st.led_period));
    ck_led_ticks = led_shift ? 9'd0 : lt_inc;
    ck_spread = (led_shift && (st.led_spread != 4'd0)) ? st.led_spread - 4'd1 : st.led_spread;
    ck_led = led_shift ? {st.led_reg[6:0], 1'b0} : st.led_reg;
    ck_rem = st.remaining_time;
    ck_done = 1'b0;
    if (st.remaining_time == 9'd0) begin
      ck_rem = st.set_time;
      ck_done = 1'b1;
      ck_led = 8'd0;
    end
    ck_phase = st.second_phase + 4'd1;
    if (ck_phase >= cfg.ticks_per_second) begin
      ck_phase = 4'd0;
      if (ck_rem != 9'd0) begin
        ck_rem = ck_rem - 9'd1;
      end
    end

    case (st.mode_reg)
      MODE_BAKE:  new_mode = MODE_TOAST;
      MODE_TOAST: new_mode = MODE_BROIL;
      default:    new_mode = MODE_BAKE;
    endcase

    st_next = st;
    if (item.tick) begin
      st_next.free_time = st.free_time + 16'd1;
    end
    held = st_next.free_time - st.press_stamp;
    long_hold = held >= {8'd0, cfg.hold_ticks};
    total = 13'd0;
    quot = 13'd0;

    case (st.oven_state)
      ST_SETUP: begin
        if (item.adc_valid) begin
          if ((st.mode_reg == MODE_BAKE) && st.edit_flag) begin
            st_next.temp_setting = (temp_sum > {1'b0, TEMP_MAX}) ? TEMP_MAX : temp_sum[9:0];
          end else begin
            st_next.set_time = 9'(knob) + 9'd1;
            st_next.remaining_time = 9'(knob) + 9'd1;
          end
        end
        total = 13'(st_next.set_time * cfg.ticks_per_second);
        quot = 13'(total / LED_COUNT);
        if (item.button3_down) begin
          st_next.press_stamp = st_next.free_time;
          st_next.oven_state = ST_SELECT;
        end else if (item.button4_down) begin
          st_next.second_phase = 4'd0;
          st_next.oven_state = ST_COOK;
          st_next.led_reg = ALL_LEDS;
          st_next.led_period = (quot > 13'(PERIOD_MAX)) ? PERIOD_MAX : quot[8:0];
          st_next.led_spread = 4'(total % LED_COUNT);
          st_next.led_ticks = 9'd0;
        end
      end
      ST_SELECT: begin
        if (item.button3_up) begin
          if (long_hold) begin
            if (st.mode_reg == MODE_BAKE) begin
              st_next.edit_flag = !st.edit_flag;
            end
          end else begin
            st_next.mode_reg = new_mode;
            if (new_mode == MODE_BROIL) begin
              st_next.saved_temp = st.temp_setting;
              st_next.temp_setting = cfg.broil_temperature;
            end else if (new_mode == MODE_BAKE) begin
              st_next.temp_setting = st.saved_temp;
            end
          end
          st_next.oven_state = ST_SETUP;
        end
      end
      ST_COOK, ST_RESETP: begin
        if (item.tick) begin
          st_next.led_ticks = ck_led_ticks;
          st_next.led_spread = ck_spread;
          st_next.led_reg = ck_led;
          st_next.remaining_time = ck_rem;
          st_next.second_phase = ck_phase;
          if (ck_done) begin
            st_next.oven_state = ST_DONE;
          end
        end
        if (st.oven_state == ST_COOK) begin
          if (item.button4_down) begin
            st_next.oven_state = ST_RESETP;
            st_next.press_stamp = st_next.free_time;
          end
        end else begin
          if (long_hold) begin
            st_next.remaining_time = st.set_time;
            st_next.oven_state = ST_SETUP;
            st_next.led_reg = 8'd0;
          end
          if (item.button4_up && !long_hold) begin
            st_next.oven_state = ST_COOK;
          end
        end
      end
      default: begin
        if (item.tick) begin
          st_next.invert_flag = !st.invert_flag;
        end
        if (item.button4_up) begin
          st_next.invert_flag = 1'b1;
          st_next.oven_state = ST_SETUP;
        end
      end
    endcase
  end

  always_comb begin
    result.state_code = st_next.oven_state;
    result.cook_mode = st_next.mode_reg;
    if ((st_next.oven_state == ST_COOK) || (st_next.oven_state == ST_RESETP)) begin
      result.shown_time = st_next.remaining_time;
    end else begin
      result.shown_time = st_next.set_time;
    end
    result.temperature = st_next.temp_setting;
    result.led_bar = st_next.led_reg;
    result.display_inverted = st_next.invert_flag;
    result.editing_temperature = st_next.edit_flag;
  end

endmodule

// File: rtl/oven_timer_controller_core.sv
// Accepted events wait in the input register; each result is registered once the output
// register is free. Throughput: one event per cycle unless the output stalls; the state
// register loops through the update logic, and an output register decouples stalls.
// Reset is synchronous: it clears the state to setup/bake with temperature 350,
// restores the default register values and empties both stages.
module oven_timer_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [otc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tick, adc_sample[9:0], button3_down, button3_up, button4_down, button4_up, zero pad
  input  logic [otc_pkg::IN_DATA_W-1:0]  s_tdata,
  // adc_valid
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // state_code[2:0], cook_mode[1:0], shown_time[8:0], temperature[9:0], led_bar[7:0],
  // display_inverted, editing_temperature, zero pad
  output logic [otc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import otc_pkg::*;

  otc_cfg_t    cfg_q;
  otc_regs_t   st_q;
  otc_regs_t   st_next;
  otc_item_t   item;
  otc_result_t result;
  logic        item_valid;
  logic        advance;

  assign advance = item_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.ticks_per_second <= TPS_RESET;
      cfg_q.hold_ticks <= HOLD_RESET;
      cfg_q.bake_temp_base <= BAKE_BASE_RESET;
      cfg_q.broil_temperature <= BROIL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data[3:0];
        REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data[7:0];
        REG_BAKE_TEMP_BASE: cfg_q.bake_temp_base <= cfg_data;
        REG_BROIL_TEMPERATURE: cfg_q.broil_temperature <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  otc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .advance   (advance),
    .item_valid(item_valid),
    .item      (item)
  );

  otc_update u_update (
    .cfg    (cfg_q),
    .item   (item),
    .st     (st_q),
    .st_next(st_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_q.oven_state <= ST_SETUP;
      st_q.mode_reg <= MODE_BAKE;
      st_q.edit_flag <= 1'b0;
      st_q.temp_setting <= TEMP_RESET;
      st_q.saved_temp <= 10'd0;
      st_q.set_time <= 9'd0;
      st_q.remaining_time <= 9'd0;
      st_q.free_time <= 16'd0;
      st_q.press_stamp <= 16'd0;
      st_q.second_phase <= 4'd0;
      st_q.led_period <= 9'd0;
      st_q.led_spread <= 4'd0;
      st_q.led_ticks <= 9'd0;
      st_q.led_reg <= 8'd0;
      st_q.invert_flag <= 1'b0;
    end else if (advance) begin
      st_q <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, result.editing_temperature, result.display_inverted,
                  result.led_bar, result.temperature, result.shown_time,
                  result.cook_mode, result.state_code};
    end
  end

  a_spread_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(st_q.led_spread) < LED_COUNT)
    else $error("LED spread count reached the LED count");

  a_period_capped: assert property (@(posedge clk) disable iff (rst)
    st_q.led_period <= PERIOD_MAX)
    else $error("LED period above its cap");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("Processed item did not produce a result");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st_q))
    else $error("Controller state changed without an item");

endmodule
